FILE: sv/lobm_pkg.sv
`timescale 1ns / 1ps
package lobm_pkg;

    localparam logic [5:0] MAX_TRADES = 6'd32;

    localparam logic [2:0] RK_TRADE     = 3'd0;
    localparam logic [2:0] RK_RESTED    = 3'd1;
    localparam logic [2:0] RK_FILLED    = 3'd2;
    localparam logic [2:0] RK_MKT_REJ   = 3'd3;
    localparam logic [2:0] RK_CANCELLED = 3'd4;
    localparam logic [2:0] RK_NOT_FOUND = 3'd5;
    localparam logic [2:0] RK_TBL_FULL  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_TRADE,
        ST_FINAL_SCAN,
        ST_FINAL_OUT
    } t_state;

    typedef struct packed {
        logic        is_buy;
        logic [31:0] order_id;
        logic [31:0] price;
        logic [31:0] remaining;
        logic [31:0] arrival;
    } t_slot;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       cancel_clear;
        logic       trade;
        logic       rest;
        logic       emit_final;
        logic [2:0] final_kind;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic is_cancel;
        logic cancel_hit;
        logic rem_zero;
        logic opp_found;
        logic crosses;
        logic trade_room;
        logic is_market;
        logic free_found;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/lobm_ctrl.sv
`timescale 1ns / 1ps
module lobm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lobm_pkg::t_sts  i_sts,
    output lobm_pkg::t_cmd  o_cmd
);

    lobm_pkg::t_state r_state, n_state;
    logic [2:0]       r_kind, n_kind;
    logic             w_do_trade;

    assign w_do_trade = !i_sts.rem_zero && i_sts.trade_room && i_sts.opp_found
                        && (i_sts.is_market || i_sts.crosses);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lobm_pkg::ST_IDLE;
            r_kind  <= lobm_pkg::RK_FILLED;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lobm_pkg::ST_IDLE:       if (i_in_valid) n_state = lobm_pkg::ST_SCAN;
            lobm_pkg::ST_SCAN:       if (i_sts.scan_done) n_state = lobm_pkg::ST_EVAL;
            lobm_pkg::ST_EVAL: begin
                if (!i_sts.is_cancel && w_do_trade) n_state = lobm_pkg::ST_TRADE;
                else n_state = lobm_pkg::ST_FINAL_SCAN;
            end
            lobm_pkg::ST_TRADE:      if (i_sts.out_free) n_state = lobm_pkg::ST_SCAN;
            lobm_pkg::ST_FINAL_SCAN: if (i_sts.scan_done) n_state = lobm_pkg::ST_FINAL_OUT;
            lobm_pkg::ST_FINAL_OUT:  if (i_sts.out_free) n_state = lobm_pkg::ST_IDLE;
            default:                 n_state = lobm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_kind     = r_kind;
        o_cmd.final_kind = r_kind;
        unique case (r_state)
            lobm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                end
            end
            lobm_pkg::ST_EVAL: begin
                if (i_sts.is_cancel) begin
                    o_cmd.scan_start   = 1'b1;
                    o_cmd.cancel_clear = i_sts.cancel_hit;
                    n_kind = i_sts.cancel_hit ? lobm_pkg::RK_CANCELLED
                                              : lobm_pkg::RK_NOT_FOUND;
                end else if (!w_do_trade) begin
                    o_cmd.scan_start = 1'b1;
                    priority if (i_sts.rem_zero) begin
                        n_kind = lobm_pkg::RK_FILLED;
                    end else if (i_sts.is_market) begin
                        n_kind = lobm_pkg::RK_MKT_REJ;
                    end else if (i_sts.free_found) begin
                        n_kind     = lobm_pkg::RK_RESTED;
                        o_cmd.rest = 1'b1;
                    end else begin
                        n_kind = lobm_pkg::RK_TBL_FULL;
                    end
                end
            end
            lobm_pkg::ST_TRADE: begin
                if (i_sts.out_free) begin
                    o_cmd.trade      = 1'b1;
                    o_cmd.scan_start = 1'b1;
                end
            end
            lobm_pkg::ST_FINAL_OUT: begin
                o_cmd.emit_final = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

FILE: sv/lobm_dp.sv
`timescale 1ns / 1ps
module lobm_dp #(
    parameter int ORDER_SLOTS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lobm_pkg::t_cmd  i_cmd,
    output lobm_pkg::t_sts  o_sts,
    input  logic            i_kind,
    input  logic [31:0]     i_order_id,
    input  logic            i_is_buy,
    input  logic            i_is_market,
    input  logic [31:0]     i_price,
    input  logic [31:0]     i_quantity,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [2:0]      o_result_kind,
    output logic [255:0]    o_out_data,
    output logic            o_out_last
);

    localparam int SW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);

    lobm_pkg::t_slot r_mem [ORDER_SLOTS];
    logic [ORDER_SLOTS-1:0] r_valid;
    logic [31:0] r_counter, r_stamp;

    logic        r_cancel, r_buy, r_market;
    logic [31:0] r_id, r_price, r_rem;
    logic [5:0]  r_ntr;

    logic [CW-1:0] r_scan_idx;
    logic          r_scan_on, r_rd_vld, r_done;
    logic [SW-1:0] r_rd_idx;
    lobm_pkg::t_slot r_rd;

    lobm_pkg::t_slot r_bb, r_ba;
    logic [31:0]     r_bb_age, r_ba_age;
    logic [SW-1:0]   r_bb_slot, r_ba_slot, r_hb_slot, r_ha_slot, r_free_slot;
    logic            r_bb_f, r_ba_f, r_hb_f, r_ha_f, r_free_f;

    logic        r_out_valid, r_out_last;
    logic [2:0]  r_out_kind;
    logic [255:0] r_out_data;

    logic [31:0]     w_age;
    logic            w_v, w_bid_better, w_ask_better;
    lobm_pkg::t_slot w_opp;
    logic [SW-1:0]   w_opp_slot;
    logic [31:0]     w_q, w_new_rem, w_bid_id, w_ask_id;
    logic            w_out_free;

    assign w_age = r_counter - r_rd.arrival;
    assign w_v   = r_rd_vld && r_valid[r_rd_idx];
    assign w_bid_better = w_v && r_rd.is_buy && (!r_bb_f || r_rd.price > r_bb.price
                          || (r_rd.price == r_bb.price && w_age > r_bb_age));
    assign w_ask_better = w_v && !r_rd.is_buy && (!r_ba_f || r_rd.price < r_ba.price
                          || (r_rd.price == r_ba.price && w_age > r_ba_age));

    assign w_opp      = r_buy ? r_ba : r_bb;
    assign w_opp_slot = r_buy ? r_ba_slot : r_bb_slot;
    assign w_q        = (r_rem < w_opp.remaining) ? r_rem : w_opp.remaining;
    assign w_new_rem  = w_opp.remaining - w_q;
    assign w_bid_id   = r_buy ? r_id : w_opp.order_id;
    assign w_ask_id   = r_buy ? w_opp.order_id : r_id;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.scan_done  = r_done;
        o_sts.is_cancel  = r_cancel;
        o_sts.cancel_hit = r_hb_f || r_ha_f;
        o_sts.rem_zero   = (r_rem == 32'd0);
        o_sts.opp_found  = r_buy ? r_ba_f : r_bb_f;
        o_sts.crosses    = r_buy ? (r_price >= r_ba.price) : (r_price <= r_bb.price);
        o_sts.trade_room = (r_ntr < lobm_pkg::MAX_TRADES);
        o_sts.is_market  = r_market;
        o_sts.free_found = r_free_f;
        o_sts.out_free   = w_out_free;
    end

    // slot store: one write, one scan read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.trade) begin
            r_mem[w_opp_slot] <= '{is_buy: w_opp.is_buy, order_id: w_opp.order_id,
                                   price: w_opp.price, remaining: w_new_rem,
                                   arrival: w_opp.arrival};
        end else if (i_cmd.rest) begin
            r_mem[r_free_slot] <= '{is_buy: r_buy, order_id: r_id, price: r_price,
                                    remaining: r_rem, arrival: r_stamp};
        end
        r_rd <= r_mem[r_scan_idx[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_counter <= '0;
            r_scan_on <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cmd.load && !i_kind) r_counter <= r_counter + 32'd1;
            if (i_cmd.trade && w_new_rem == 32'd0) r_valid[w_opp_slot] <= 1'b0;
            if (i_cmd.rest) r_valid[r_free_slot] <= 1'b1;
            if (i_cmd.cancel_clear) r_valid[r_hb_f ? r_hb_slot : r_ha_slot] <= 1'b0;
            r_rd_vld <= r_scan_on;
            r_done   <= r_rd_vld && (r_rd_idx == SW'(ORDER_SLOTS - 1));
            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
            end else if (r_scan_on && r_scan_idx == CW'(ORDER_SLOTS - 1)) begin
                r_scan_on <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cancel <= i_kind;
            r_id     <= i_order_id;
            r_buy    <= i_is_buy;
            r_market <= i_is_market;
            r_price  <= i_price;
            r_rem    <= i_quantity;
            r_stamp  <= r_counter;
            r_ntr    <= '0;
        end else if (i_cmd.trade) begin
            r_rem <= r_rem - w_q;
            r_ntr <= r_ntr + 6'd1;
        end
        r_rd_idx <= r_scan_idx[SW-1:0];
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
            r_bb_f <= 1'b0;
            r_ba_f <= 1'b0;
            r_hb_f <= 1'b0;
            r_ha_f <= 1'b0;
            r_free_f <= 1'b0;
        end else begin
            if (r_scan_on) r_scan_idx <= r_scan_idx + CW'(1);
            if (w_bid_better) begin
                r_bb_f <= 1'b1; r_bb <= r_rd; r_bb_age <= w_age; r_bb_slot <= r_rd_idx;
            end
            if (w_ask_better) begin
                r_ba_f <= 1'b1; r_ba <= r_rd; r_ba_age <= w_age; r_ba_slot <= r_rd_idx;
            end
            if (w_v && r_rd.is_buy && r_rd.order_id == r_id && !r_hb_f) begin
                r_hb_f <= 1'b1; r_hb_slot <= r_rd_idx;
            end
            if (w_v && !r_rd.is_buy && r_rd.order_id == r_id && !r_ha_f) begin
                r_ha_f <= 1'b1; r_ha_slot <= r_rd_idx;
            end
            if (r_rd_vld && !r_valid[r_rd_idx] && !r_free_f) begin
                r_free_f <= 1'b1; r_free_slot <= r_rd_idx;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.trade || i_cmd.emit_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.trade) begin
            r_out_kind <= lobm_pkg::RK_TRADE;
            r_out_last <= 1'b0;
            r_out_data <= {128'd0, w_q, w_opp.price, w_ask_id, w_bid_id};
        end else if (i_cmd.emit_final) begin
            r_out_kind <= i_cmd.final_kind;
            r_out_last <= 1'b1;
            r_out_data <= {r_ba_f ? r_ba.remaining : 32'd0,
                           r_bb_f ? r_bb.remaining : 32'd0,
                           r_ba_f ? r_ba.price : 32'd0,
                           r_bb_f ? r_bb.price : 32'd0, 128'd0};
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_out_data    = r_out_data;
    assign o_out_last    = r_out_last;

endmodule

FILE: sv/limit_order_book_matcher_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                                 Contents
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready           one request: new order or cancel
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready           trades, then one status with tlast
//
// Each table pass reads one slot per cycle from the slot store and is followed by
// one decision state. A cancel takes two passes and never trades.
// Reset (i_rst_n low, synchronous) empties the table and zeroes the arrival count.
// A stalled output holds the engine before the next trade or status is loaded.
module limit_order_book_matcher_core #(
    parameter int ORDER_SLOTS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // order_id[31:0], is_buy[32], is_market[33], price[65:34], quantity[97:66]
    input  logic [103:0] i_s_axis_tdata,
    // kind[0]
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // buy_order_id, sell_order_id, trade_price, trade_quantity,
    // best_bid_price, best_ask_price, best_bid_quantity, best_ask_quantity
    output logic [255:0] o_m_axis_tdata,
    // result_kind[2:0]
    output logic [2:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);

    lobm_pkg::t_cmd w_cmd;
    lobm_pkg::t_sts w_sts;

    lobm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lobm_dp #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_kind        (i_s_axis_tuser[0]),
        .i_order_id    (i_s_axis_tdata[31:0]),
        .i_is_buy      (i_s_axis_tdata[32]),
        .i_is_market   (i_s_axis_tdata[33]),
        .i_price       (i_s_axis_tdata[65:34]),
        .i_quantity    (i_s_axis_tdata[97:66]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_result_kind (o_m_axis_tuser),
        .o_out_data    (o_m_axis_tdata),
        .o_out_last    (o_m_axis_tlast)
    );

endmodule

FILE: bench/tb_limit_order_book_matcher_core.sv
`timescale 1ns / 1ps
// Order book matcher bench: requests (new orders and cancels) are driven on the
// slave stream, the bench keeps its own copy of the order table and works out
// the trades and the closing status of every request, and each result beat on
// the master stream is compared field by field with the oldest expected one.
module tb_limit_order_book_matcher_core;

    localparam int SLOTS     = 32;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] buy_id;
        logic [31:0] sell_id;
        logic [31:0] px;
        logic [31:0] qty;
        logic        last;
        logic [31:0] bid_px;
        logic [31:0] ask_px;
        logic [31:0] bid_qty;
        logic [31:0] ask_qty;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [103:0] i_s_axis_tdata = '0;
    logic [0:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [255:0] o_m_axis_tdata;
    logic [2:0]   o_m_axis_tuser;
    logic         o_m_axis_tlast;

    always #6 i_clk = ~i_clk;

    limit_order_book_matcher_core #(.ORDER_SLOTS(SLOTS)) dut (.*);

    // predicted book
    logic        bk_valid [SLOTS];
    logic        bk_buy   [SLOTS];
    logic [31:0] bk_id    [SLOTS];
    logic [31:0] bk_px    [SLOTS];
    logic [31:0] bk_rem   [SLOTS];
    logic [31:0] bk_stamp [SLOTS];
    logic [31:0] arrivals;

    t_result expected_results[$];
    int      err_count;
    int      n_requests;
    int      n_results;
    int      n_trades;
    int      idle_cycles;
    bit      rx_hold;     // long receiver hold-off
    bit      rx_random;   // random receiver stalls
    int      tx_gap_max;

    function automatic int best_of(logic side);
        int best;
        logic [31:0] age, best_age;
        best = -1;
        for (int s = 0; s < SLOTS; s++) begin
            if (!bk_valid[s] || bk_buy[s] != side) continue;
            if (best < 0) begin
                best = s;
                continue;
            end
            age = arrivals - bk_stamp[s];
            best_age = arrivals - bk_stamp[best];
            if (side ? (bk_px[s] > bk_px[best]) : (bk_px[s] < bk_px[best]))
                best = s;
            else if (bk_px[s] == bk_px[best] && age > best_age)
                best = s;
        end
        return best;
    endfunction

    function automatic void queue_result(t_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void push_status(logic [2:0] kind);
        t_result r;
        int b, a;
        r = '{default: '0};
        r.kind = kind;
        r.last = 1'b1;
        b = best_of(1'b1);
        a = best_of(1'b0);
        if (b >= 0) begin
            r.bid_px = bk_px[b];
            r.bid_qty = bk_rem[b];
        end
        if (a >= 0) begin
            r.ask_px = bk_px[a];
            r.ask_qty = bk_rem[a];
        end
        queue_result(r);
    endfunction

    // Book update for one accepted request; queues trades and the status.
    function automatic void predict_book(logic cancel, logic [31:0] id, logic buy,
                                         logic mkt, logic [31:0] px, logic [31:0] qty);
        int hit, r, f, n;
        logic [31:0] rem, q, stamp;
        t_result t;
        if (cancel) begin
            hit = -1;
            // bids are searched before asks, lowest slot first
            for (int pass = 0; pass < 2 && hit < 0; pass++)
                for (int s = 0; s < SLOTS && hit < 0; s++)
                    if (bk_valid[s] && bk_buy[s] == (pass == 0) && bk_id[s] == id)
                        hit = s;
            if (hit >= 0) bk_valid[hit] = 1'b0;
            push_status(hit >= 0 ? lobm_pkg::RK_CANCELLED : lobm_pkg::RK_NOT_FOUND);
            return;
        end
        stamp = arrivals;
        arrivals = arrivals + 1;
        rem = qty;
        n = 0;
        while (rem != 0 && n < int'(lobm_pkg::MAX_TRADES)) begin
            r = best_of(!buy);
            if (r < 0) break;
            if (!mkt && !(buy ? (px >= bk_px[r]) : (px <= bk_px[r]))) break;
            q = (rem < bk_rem[r]) ? rem : bk_rem[r];
            t = '{default: '0};
            t.kind = lobm_pkg::RK_TRADE;
            t.buy_id = buy ? id : bk_id[r];
            t.sell_id = buy ? bk_id[r] : id;
            t.px = bk_px[r];
            t.qty = q;
            queue_result(t);
            n++;
            rem -= q;
            bk_rem[r] -= q;
            if (bk_rem[r] == 0) bk_valid[r] = 1'b0;
        end
        if (rem == 0) begin
            push_status(lobm_pkg::RK_FILLED);
        end else if (mkt) begin
            push_status(lobm_pkg::RK_MKT_REJ);
        end else begin
            f = -1;
            for (int s = 0; s < SLOTS && f < 0; s++)
                if (!bk_valid[s]) f = s;
            if (f < 0) begin
                push_status(lobm_pkg::RK_TBL_FULL);
            end else begin
                bk_valid[f] = 1'b1;
                bk_buy[f] = buy;
                bk_id[f] = id;
                bk_px[f] = px;
                bk_rem[f] = rem;
                bk_stamp[f] = stamp;
                push_status(lobm_pkg::RK_RESTED);
            end
        end
    endfunction

    function automatic int gap_len(int max_gap);
        if (max_gap == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, max_gap);
        return $urandom_range(0, 2);
    endfunction

    // Drives one request and waits for its acceptance.
    task automatic send_request(logic cancel, logic [31:0] id, logic buy, logic mkt,
                                logic [31:0] px, logic [31:0] qty);
        repeat (gap_len(tx_gap_max)) @(posedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {6'b0, qty, px, mkt, buy, id};
        i_s_axis_tuser <= cancel;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_book(cancel, id, buy, mkt, px, qty);
        n_requests++;
        i_s_axis_tvalid <= 1'b0;
        // the block is not ready again until it has finished this request anyway
        @(posedge i_clk);
    endtask

    task automatic new_order(logic [31:0] id, logic buy, logic mkt,
                             logic [31:0] px, logic [31:0] qty);
        send_request(1'b0, id, buy, mkt, px, qty);
    endtask

    task automatic cancel_order(logic [31:0] id);
        send_request(1'b1, id, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3 * (SLOTS + 3)) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %0h expected %0h", n_results, what, got, want);
        err_count++;
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n || rx_hold) i_m_axis_tready <= 1'b0;
        else if (rx_random) i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        else i_m_axis_tready <= 1'b1;
    end

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("MISMATCH unexpected result beat, kind %0d", o_m_axis_tuser);
                err_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_m_axis_tuser != e.kind) report_mismatch("kind", o_m_axis_tuser, e.kind);
                if (o_m_axis_tlast != e.last) report_mismatch("last", o_m_axis_tlast, e.last);
                if (o_m_axis_tdata[31:0] != e.buy_id)
                    report_mismatch("buy id", o_m_axis_tdata[31:0], e.buy_id);
                if (o_m_axis_tdata[63:32] != e.sell_id)
                    report_mismatch("sell id", o_m_axis_tdata[63:32], e.sell_id);
                if (o_m_axis_tdata[95:64] != e.px)
                    report_mismatch("trade price", o_m_axis_tdata[95:64], e.px);
                if (o_m_axis_tdata[127:96] != e.qty)
                    report_mismatch("trade qty", o_m_axis_tdata[127:96], e.qty);
                if (o_m_axis_tdata[159:128] != e.bid_px)
                    report_mismatch("best bid", o_m_axis_tdata[159:128], e.bid_px);
                if (o_m_axis_tdata[191:160] != e.ask_px)
                    report_mismatch("best ask", o_m_axis_tdata[191:160], e.ask_px);
                if (o_m_axis_tdata[223:192] != e.bid_qty)
                    report_mismatch("bid qty", o_m_axis_tdata[223:192], e.bid_qty);
                if (o_m_axis_tdata[255:224] != e.ask_qty)
                    report_mismatch("ask qty", o_m_axis_tdata[255:224], e.ask_qty);
                if (e.kind == lobm_pkg::RK_TRADE) n_trades++;
            end
            n_results++;
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired, %0d results outstanding", expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Crossing, time priority, partial fills, zero qty, market reject, cancel cases.
    task automatic test_directed();
        new_order(32'd1, 1'b1, 1'b0, 32'd100, 32'd10);
        new_order(32'd2, 1'b1, 1'b0, 32'd100, 32'd5);           // same price, later
        new_order(32'd3, 1'b1, 1'b0, 32'd0, 32'd7);             // bid at price zero
        new_order(32'd4, 1'b0, 1'b0, 32'd101, 32'd3);           // no cross, rests
        new_order(32'd5, 1'b0, 1'b0, 32'd90, 32'd12);           // hits id 1 then id 2
        new_order(32'd6, 1'b0, 1'b0, 32'd50, 32'd0);            // zero quantity
        new_order(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd10); // market buy runs dry
        new_order(32'd7, 1'b0, 1'b1, 32'd0, 32'hFFFF_FFFF);     // market sell sweeps bids
        new_order(32'd8, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        new_order(32'd9, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd1);
        new_order(32'd8, 1'b1, 1'b0, 32'd1, 32'd4);             // duplicate id on bid side
        cancel_order(32'd8);                                    // bid goes first
        cancel_order(32'd8);
        cancel_order(32'd8);                                    // now unknown
        cancel_order(32'd0);
        // fill the table, then overflow it
        for (int i = 0; i < SLOTS; i++)
            new_order(32'd100 + i, 1'b1, 1'b0, 32'd10 + (i % 3), 32'd1);
        new_order(32'd200, 1'b1, 1'b0, 32'd5, 32'd1);           // table full
        new_order(32'd201, 1'b0, 1'b0, 32'd1, 32'd40);          // sweeps all, then rests
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_back_pressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                new_order($urandom_range(0, 15), i[0], 1'b0, $urandom_range(95, 105),
                          $urandom_range(1, 20));
        join
        wait_drained();
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            new_order($urandom_range(0, 40), $urandom, 1'b0, $urandom_range(90, 110),
                      $urandom_range(1, 50));
        else if (pick < 80)
            new_order($urandom_range(0, 40), $urandom, 1'b1, $urandom, $urandom_range(1, 80));
        else if (pick < 95)
            cancel_order($urandom_range(0, 40));
        else
            send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Random book traffic in bursts, some with idle sender and stalls, some without.
    task automatic test_random_book();
        for (int blk = 0; blk < 8; blk++) begin
            rx_random = blk[0];
            tx_gap_max = blk[1] ? 60 : 0;
            repeat (45) random_request();
            if (blk == 3) wait_drained();   // sender waits for everything to come back
        end
        // price extremes exercise the full 32-bit fields
        for (int i = 0; i < 10; i++)
            new_order($urandom, $urandom, 1'b0, i[0] ? 32'hFFFF_FFFF : 32'd0, $urandom);
        rx_random = 1'b0;
        wait_drained();
    endtask

    initial begin
        err_count = 0;
        n_requests = 0;
        n_results = 0;
        n_trades = 0;
        idle_cycles = 0;
        rx_hold = 1'b0;
        rx_random = 1'b0;
        tx_gap_max = 0;
        arrivals = '0;
        for (int s = 0; s < SLOTS; s++) begin
            bk_valid[s] = 1'b0;
            bk_buy[s] = 1'b0;
            bk_id[s] = '0;
            bk_px[s] = '0;
            bk_rem[s] = '0;
            bk_stamp[s] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_back_pressure();
        test_random_book();
        $display("Covered %0d requests (orders, cancels, market sweeps, table full)",
                 n_requests);
        $display("and checked %0d result beats including %0d trades", n_results, n_trades);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
